### src/mm_pkg.sv
// Shared types and constants for the Montgomery multiplier.
package mm_pkg;

  localparam int LIMB_W = 16;
  localparam int IDX_W  = 6;
  localparam int LC_W   = 7;

  localparam logic [2:0] KIND_LOAD_MOD = 3'd0;
  localparam logic [2:0] KIND_LOAD_OPS = 3'd1;
  localparam logic [2:0] KIND_MULTIPLY = 3'd2;
  localparam logic [2:0] KIND_REDUCE   = 3'd3;
  localparam logic [2:0] KIND_READ     = 3'd4;

  localparam logic CFG_LIMB_COUNT  = 1'b0;
  localparam logic CFG_NEG_INVERSE = 1'b1;

  typedef struct packed {
    logic                load_mod;
    logic                load_ops;
    logic                start;
    logic                reduce_only;
    logic                rd;
    logic                idx_ok;
    logic [IDX_W-1:0]    idx;
    logic [LIMB_W-1:0]   a;
    logic [LIMB_W-1:0]   b;
    logic [LIMB_W-1:0]   m;
  } cmd_t;

endpackage

### src/montgomery_multiplier.sv
// Top level of the Montgomery multiplier: handshakes, registers, result output.
//
// Requests arrive on the in_ channel (valid/stall). Load requests write one
// modulus limb or one pair of operand limbs in the cycle they are accepted.
// A multiply or reduce-only request starts the CIOS sequencer; the input
// stalls until it has finished. A read request is registered as pending
// and then raises out_valid from the output register, with the result limb
// and its index. The sequencer is limited by the single 16x16 multiplier
// and the one read port of the accumulator memory: each row touches one
// limb per cycle, with a short tail and a mu step per round. When the
// accumulator is already below the modulus after the trial subtraction,
// it is copied unchanged into the result store.
// Loads take one request per cycle while the sequencer is idle and no read
// is pending. A read holds the input while the result store is read, and it
// waits while an earlier result is still held in the output register under
// out_stall.
// Configuration (cfg_) writes are taken at any time but belong to idle time.
// Reset clears the control state and sets limb_count to 16 and neg_inverse
// to 0; the limb stores hold nothing meaningful until written.
module montgomery_multiplier #(
  parameter int MAX_LIMBS = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_kind,
  input  logic [mm_pkg::IDX_W-1:0]     in_limb_index,
  input  logic [mm_pkg::LIMB_W-1:0]    in_a_limb,
  input  logic [mm_pkg::LIMB_W-1:0]    in_b_limb,
  input  logic [mm_pkg::LIMB_W-1:0]    in_modulus_limb,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mm_pkg::LIMB_W-1:0]    out_result_limb,
  output logic [mm_pkg::IDX_W-1:0]     out_result_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [mm_pkg::LIMB_W-1:0]    cfg_data
);

  logic [mm_pkg::LC_W-1:0]   limb_count_r;
  logic [mm_pkg::LIMB_W-1:0] neg_inverse_r;
  logic                      rd_pend_r, rd_ok_r, out_valid_r;
  logic [mm_pkg::IDX_W-1:0]  rd_idx_r, out_idx_r;
  logic [mm_pkg::LIMB_W-1:0] out_limb_r, rd_data;
  logic                      busy, accept;
  mm_pkg::cmd_t              cmd;

  assign cfg_ready = 1'b1;

  assign in_stall = busy || rd_pend_r ||
                    (in_kind == mm_pkg::KIND_READ && out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd.load_mod    = (in_kind == mm_pkg::KIND_LOAD_MOD);
    cmd.load_ops    = (in_kind == mm_pkg::KIND_LOAD_OPS);
    cmd.start       = in_kind inside {mm_pkg::KIND_MULTIPLY, mm_pkg::KIND_REDUCE};
    cmd.reduce_only = (in_kind == mm_pkg::KIND_REDUCE);
    cmd.rd          = (in_kind == mm_pkg::KIND_READ);
    cmd.idx_ok      = (32'(in_limb_index) < MAX_LIMBS);
    cmd.idx         = in_limb_index;
    cmd.a           = in_a_limb;
    cmd.b           = in_b_limb;
    cmd.m           = in_modulus_limb;
  end

  mm_core #(.MAX_LIMBS(MAX_LIMBS)) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_vld     (accept),
    .cmd         (cmd),
    .limb_count  (limb_count_r),
    .neg_inverse (neg_inverse_r),
    .busy        (busy),
    .rd_data     (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limb_count_r  <= mm_pkg::LC_W'(16);
      neg_inverse_r <= '0;
      rd_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mm_pkg::CFG_LIMB_COUNT) begin
          limb_count_r <= cfg_data[mm_pkg::LC_W-1:0];
        end else begin
          neg_inverse_r <= cfg_data;
        end
      end
      rd_pend_r <= accept && cmd.rd;
      if (rd_pend_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx_r <= in_limb_index;
      rd_ok_r  <= cmd.idx_ok;
    end
    if (rd_pend_r) begin
      out_limb_r <= rd_ok_r ? rd_data : '0;
      out_idx_r  <= rd_idx_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_limb  = out_limb_r;
  assign out_result_index = out_idx_r;

endmodule

### src/mm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/mm_core.sv
// Limb stores and the CIOS row sequencer with one shared 16x16 multiplier.
module mm_core #(
  parameter int MAX_LIMBS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cmd_vld,
  input  mm_pkg::cmd_t                cmd,
  input  logic [mm_pkg::LC_W-1:0]     limb_count,
  input  logic [mm_pkg::LIMB_W-1:0]   neg_inverse,
  output logic                        busy,
  output logic [mm_pkg::LIMB_W-1:0]   rd_data
);

  localparam int AW = $clog2(MAX_LIMBS);
  localparam int CW = $clog2(MAX_LIMBS + 1);
  localparam int LW = mm_pkg::LIMB_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MROW  = 4'd1;
  localparam logic [3:0] S_MTAIL = 4'd2;
  localparam logic [3:0] S_RMU   = 4'd3;
  localparam logic [3:0] S_RROW  = 4'd4;
  localparam logic [3:0] S_RTAIL = 4'd5;
  localparam logic [3:0] S_RPRE  = 4'd6;
  localparam logic [3:0] S_FSUB  = 4'd7;
  localparam logic [3:0] S_FCHK  = 4'd8;
  localparam logic [3:0] S_FCOPY = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] k_r, k_nxt, i_r, i_nxt, n_r, n_nxt;
  logic          p_vld_r, p_vld_nxt;
  logic [AW-1:0] p_k_r, p_k_nxt;
  logic [LW-1:0] carry_r, carry_nxt, mu_r, mu_nxt, hi0_r, hi0_nxt, hi1_r, hi1_nxt;
  logic          borrow_r, borrow_nxt, zero_t_r, zero_t_nxt, src_a_r, src_a_nxt;
  logic          red_r, red_nxt;

  // memory ports
  logic          m_we, m_re, a_we, a_re, b_re, t_we, t_re, r_we, r_re;
  logic [AW-1:0] m_waddr, m_raddr, a_waddr, a_raddr, b_raddr;
  logic [AW-1:0] t_waddr, t_raddr, r_waddr, r_raddr;
  logic [LW-1:0] m_rd, a_rd, b_rd, t_rd, t_wdata, r_wdata;

  logic [CW-1:0]   n_clamp;
  logic            issue, last;
  logic [LW-1:0]   t_in, mul_x, mul_y;
  logic [2*LW-1:0] prod, acc_sum;
  logic [LW:0]     tail_sum, diff;

  mm_ram #(.WIDTH(LW), .DEPTH(MAX_LIMBS)) u_mod_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(cmd.m),
    .re(m_re), .raddr(m_raddr), .rdata(m_rd)
  );
  mm_ram #(.WIDTH(LW), .DEPTH(MAX_LIMBS)) u_a_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(cmd.a),
    .re(a_re), .raddr(a_raddr), .rdata(a_rd)
  );
  mm_ram #(.WIDTH(LW), .DEPTH(MAX_LIMBS)) u_b_ram (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(cmd.b),
    .re(b_re), .raddr(b_raddr), .rdata(b_rd)
  );
  mm_ram #(.WIDTH(LW), .DEPTH(MAX_LIMBS)) u_acc_ram (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .re(t_re), .raddr(t_raddr), .rdata(t_rd)
  );
  mm_ram #(.WIDTH(LW), .DEPTH(MAX_LIMBS)) u_res_ram (
    .clk(clk), .we(r_we), .waddr(r_waddr), .wdata(r_wdata),
    .re(r_re), .raddr(r_raddr), .rdata(rd_data)
  );

  assign busy = (state_r != S_IDLE);

  always_comb begin
    if (limb_count == '0) begin
      n_clamp = CW'(1);
    end else if (32'(limb_count) > MAX_LIMBS) begin
      n_clamp = CW'(MAX_LIMBS);
    end else begin
      n_clamp = CW'(limb_count);
    end
  end

  assign issue = (k_r < n_r);
  assign last  = p_vld_r && ((CW'(p_k_r) + CW'(1)) == n_r);

  // Row 0 of a multiply starts from a cleared accumulator; row 0 of a
  // reduce-only run takes the accumulator straight from the first operand.
  assign t_in = zero_t_r ? '0 : (src_a_r ? a_rd : t_rd);

  always_comb begin
    case (state_r)
      S_MROW: begin
        mul_x = a_rd;
        mul_y = b_rd;
      end
      S_RMU: begin
        mul_x = src_a_r ? a_rd : t_rd;
        mul_y = neg_inverse;
      end
      default: begin
        mul_x = mu_r;
        mul_y = m_rd;
      end
    endcase
  end

  assign prod     = mul_x * mul_y;
  assign acc_sum  = (2*LW)'(t_in) + prod + (2*LW)'(carry_r);
  assign tail_sum = (LW+1)'(hi0_r) + (LW+1)'(carry_r);
  assign diff     = (LW+1)'(t_rd) - (LW+1)'(m_rd) - (LW+1)'(borrow_r);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    n_nxt      = n_r;
    p_vld_nxt  = 1'b0;
    p_k_nxt    = AW'(k_r);
    carry_nxt  = carry_r;
    mu_nxt     = mu_r;
    hi0_nxt    = hi0_r;
    hi1_nxt    = hi1_r;
    borrow_nxt = borrow_r;
    zero_t_nxt = zero_t_r;
    src_a_nxt  = src_a_r;
    red_nxt    = red_r;

    m_we = 1'b0;  m_waddr = AW'(cmd.idx);
    a_we = 1'b0;  a_waddr = AW'(cmd.idx);
    m_re = 1'b0;  m_raddr = AW'(k_r);
    a_re = 1'b0;  a_raddr = AW'(k_r);
    b_re = 1'b0;  b_raddr = AW'(k_r);
    t_re = 1'b0;  t_raddr = AW'(k_r);
    t_we = 1'b0;  t_waddr = p_k_r;  t_wdata = acc_sum[LW-1:0];
    r_re = 1'b0;  r_raddr = AW'(cmd.idx);
    r_we = 1'b0;  r_waddr = p_k_r;  r_wdata = diff[LW-1:0];

    case (state_r)
      S_IDLE: begin
        if (cmd_vld) begin
          m_we = cmd.load_mod && cmd.idx_ok;
          a_we = cmd.load_ops && cmd.idx_ok;
          r_re = cmd.rd;
          if (cmd.start) begin
            a_re       = 1'b1;
            a_raddr    = '0;
            n_nxt      = n_clamp;
            k_nxt      = '0;
            i_nxt      = '0;
            carry_nxt  = '0;
            hi0_nxt    = '0;
            hi1_nxt    = '0;
            red_nxt    = cmd.reduce_only;
            zero_t_nxt = !cmd.reduce_only;
            src_a_nxt  = cmd.reduce_only;
            state_nxt  = cmd.reduce_only ? S_RMU : S_MROW;
          end
        end
      end
      S_MROW: begin
        if (issue) begin
          t_re      = 1'b1;
          b_re      = 1'b1;
          p_vld_nxt = 1'b1;
          k_nxt     = k_r + CW'(1);
        end
        if (p_vld_r) begin
          t_we      = 1'b1;
          carry_nxt = acc_sum[2*LW-1:LW];
        end
        if (last) begin
          state_nxt = S_MTAIL;
        end
      end
      S_MTAIL: begin
        hi0_nxt    = tail_sum[LW-1:0];
        hi1_nxt    = LW'(tail_sum[LW]);
        zero_t_nxt = 1'b0;
        t_re       = 1'b1;
        t_raddr    = '0;
        state_nxt  = S_RMU;
      end
      S_RMU: begin
        mu_nxt    = prod[LW-1:0];
        carry_nxt = '0;
        k_nxt     = '0;
        state_nxt = S_RROW;
      end
      S_RROW: begin
        if (issue) begin
          t_re      = !src_a_r;
          a_re      = src_a_r;
          m_re      = 1'b1;
          p_vld_nxt = 1'b1;
          k_nxt     = k_r + CW'(1);
        end
        if (p_vld_r) begin
          t_we      = (p_k_r != '0);
          t_waddr   = p_k_r - AW'(1);
          carry_nxt = acc_sum[2*LW-1:LW];
        end
        if (last) begin
          state_nxt = S_RTAIL;
        end
      end
      S_RTAIL: begin
        t_we      = 1'b1;
        t_waddr   = AW'(n_r - CW'(1));
        t_wdata   = tail_sum[LW-1:0];
        hi0_nxt   = hi1_r + LW'(tail_sum[LW]);
        src_a_nxt = 1'b0;
        i_nxt     = i_r + CW'(1);
        k_nxt     = '0;
        carry_nxt = '0;
        if ((i_r + CW'(1)) == n_r) begin
          borrow_nxt = 1'b0;
          state_nxt  = S_FSUB;
        end else if (!red_r) begin
          a_re      = 1'b1;
          a_raddr   = AW'(i_r + CW'(1));
          state_nxt = S_MROW;
        end else begin
          state_nxt = S_RPRE;
        end
      end
      S_RPRE: begin
        // Kept apart from the tail so the read of limb zero never meets its write.
        t_re      = 1'b1;
        t_raddr   = '0;
        state_nxt = S_RMU;
      end
      S_FSUB: begin
        if (issue) begin
          t_re      = 1'b1;
          m_re      = 1'b1;
          p_vld_nxt = 1'b1;
          k_nxt     = k_r + CW'(1);
        end
        if (p_vld_r) begin
          r_we       = 1'b1;
          borrow_nxt = diff[LW];
        end
        if (last) begin
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        k_nxt = '0;
        // The difference already sits in the result store unless t < m.
        if (hi0_r != '0 || !borrow_r) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_FCOPY;
        end
      end
      S_FCOPY: begin
        if (issue) begin
          t_re      = 1'b1;
          p_vld_nxt = 1'b1;
          k_nxt     = k_r + CW'(1);
        end
        if (p_vld_r) begin
          r_we    = 1'b1;
          r_wdata = t_rd;
        end
        if (last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      p_vld_r <= p_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r      <= k_nxt;
    i_r      <= i_nxt;
    n_r      <= n_nxt;
    p_k_r    <= p_k_nxt;
    carry_r  <= carry_nxt;
    mu_r     <= mu_nxt;
    hi0_r    <= hi0_nxt;
    hi1_r    <= hi1_nxt;
    borrow_r <= borrow_nxt;
    zero_t_r <= zero_t_nxt;
    src_a_r  <= src_a_nxt;
    red_r    <= red_nxt;
  end

endmodule
